/* src/voxel_label_writer_core_macros.svh */
// Assertion macros for the voxel label writer core.
// Included by the top level; depends on nothing else.
`ifndef VOXEL_LABEL_WRITER_CORE_MACROS_SVH
`define VOXEL_LABEL_WRITER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define VLW_ASSERT_IMPLY(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("voxel label writer: same-cycle check failed");
// next-cycle implication
`define VLW_ASSERT_NEXT(lbl, clk, rst, cond, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("voxel label writer: next-cycle check failed");
`else
`define VLW_ASSERT_IMPLY(lbl, clk, rst, cond, prop)
`define VLW_ASSERT_NEXT(lbl, clk, rst, cond, prop)
`endif
`endif

/* src/vlw_pkg.sv */
// Shared types, codes and constants of the voxel label writer.
// No dependencies; used by every other file of the block but the assertion macros.
package vlw_pkg;

   localparam int SIDE_MAX_DEFAULT = 64;
   localparam int QUEUE_DEPTH      = 4;

   localparam int COORD_W = 20;
   localparam int LABEL_W = 32;
   localparam int SIZE_W  = 7;
   localparam int REL_W   = 6;
   localparam int COUNT_W = 19;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // operation codes
   localparam logic [1:0] OP_ANNOTATE = 2'd0;
   localparam logic [1:0] OP_WRITE    = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   // conflict modes
   localparam logic [1:0] MODE_OVERWRITE = 2'd0;
   localparam logic [1:0] MODE_PRESERVE  = 2'd1;
   localparam logic [1:0] MODE_EXCEPTION = 2'd2;

   // result status codes
   localparam logic [2:0] STATUS_LABELLED    = 3'd0;
   localparam logic [2:0] STATUS_SAME        = 3'd1;
   localparam logic [2:0] STATUS_OVERWRITTEN = 3'd2;
   localparam logic [2:0] STATUS_PRESERVED   = 3'd3;
   localparam logic [2:0] STATUS_EXCEPTION   = 3'd4;
   localparam logic [2:0] STATUS_OUTSIDE     = 3'd5;
   localparam logic [2:0] STATUS_ACCESS      = 3'd6;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_LABEL    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_MODE     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_X = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Y = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ORIGIN_Z = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_X   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Y   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_SIZE_Z   = 3'd7;

   typedef struct packed {
      logic [LABEL_W-1:0] label;
      logic [1:0]         mode;
      logic [COORD_W-1:0] origin_x;
      logic [COORD_W-1:0] origin_y;
      logic [COORD_W-1:0] origin_z;
      logic [SIZE_W-1:0]  size_x;
      logic [SIZE_W-1:0]  size_y;
      logic [SIZE_W-1:0]  size_z;
   } cfg_type;

   // classified item handed from front to back (address travels beside it)
   typedef struct packed {
      logic [1:0]         op;
      logic               outside;
      logic [REL_W-1:0]   rel_x;
      logic [REL_W-1:0]   rel_y;
      logic [REL_W-1:0]   rel_z;
      logic [LABEL_W-1:0] write_value;
      logic               final_req;
   } item_type;

   typedef struct packed {
      logic clearing;
      logic resolving;
   } back_stat_type;

endpackage

/* src/vlw_if.sv */
// Valid/ready stream interfaces of the voxel label writer.
// Depends on vlw_pkg for field widths.
interface vlw_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  op;
   logic [vlw_pkg::COORD_W-1:0] coord_x;
   logic [vlw_pkg::COORD_W-1:0] coord_y;
   logic [vlw_pkg::COORD_W-1:0] coord_z;
   logic [vlw_pkg::LABEL_W-1:0] write_value;
   logic                        final_req;

   modport source (output valid, op, coord_x, coord_y, coord_z, write_value, final_req,
                   input ready);
   modport sink   (input valid, op, coord_x, coord_y, coord_z, write_value, final_req,
                   output ready);
endinterface

interface vlw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [2:0]                  status;
   logic [vlw_pkg::LABEL_W-1:0] read_value;
   logic [vlw_pkg::REL_W-1:0]   rel_x;
   logic [vlw_pkg::REL_W-1:0]   rel_y;
   logic [vlw_pkg::REL_W-1:0]   rel_z;
   logic [vlw_pkg::COUNT_W-1:0] exception_total;

   modport source (output valid, status, read_value, rel_x, rel_y, rel_z, exception_total,
                   input ready);
   modport sink   (input valid, status, read_value, rel_x, rel_y, rel_z, exception_total,
                   output ready);
endinterface

/* src/vlw_cfg_regs.sv */
// Configuration registers of the voxel label writer.
// Depends on vlw_pkg for the register layout and indexes.
module vlw_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [vlw_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [vlw_pkg::CSR_DATA_W-1:0]      csr_data,
   output vlw_pkg::cfg_type                    cfg
);

   vlw_pkg::cfg_type cfg_ff, cfg_in;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            vlw_pkg::REG_LABEL:    cfg_in.label    = csr_data[vlw_pkg::LABEL_W-1:0];
            vlw_pkg::REG_MODE:     cfg_in.mode     = csr_data[1:0];
            vlw_pkg::REG_ORIGIN_X: cfg_in.origin_x = csr_data[vlw_pkg::COORD_W-1:0];
            vlw_pkg::REG_ORIGIN_Y: cfg_in.origin_y = csr_data[vlw_pkg::COORD_W-1:0];
            vlw_pkg::REG_ORIGIN_Z: cfg_in.origin_z = csr_data[vlw_pkg::COORD_W-1:0];
            vlw_pkg::REG_SIZE_X:   cfg_in.size_x   = csr_data[vlw_pkg::SIZE_W-1:0];
            vlw_pkg::REG_SIZE_Y:   cfg_in.size_y   = csr_data[vlw_pkg::SIZE_W-1:0];
            vlw_pkg::REG_SIZE_Z:   cfg_in.size_z   = csr_data[vlw_pkg::SIZE_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.label    <= vlw_pkg::LABEL_W'(1);
         cfg_ff.mode     <= vlw_pkg::MODE_OVERWRITE;
         cfg_ff.origin_x <= '0;
         cfg_ff.origin_y <= '0;
         cfg_ff.origin_z <= '0;
         cfg_ff.size_x   <= vlw_pkg::SIZE_W'(64);
         cfg_ff.size_y   <= vlw_pkg::SIZE_W'(64);
         cfg_ff.size_z   <= vlw_pkg::SIZE_W'(64);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* src/vlw_front.sv */
// Front end: takes request transfers, makes relative coordinates, checks the
// cube bounds and forms the linear address. Depends on vlw_pkg and vlw_if.
module vlw_front #(
   parameter int SIDE_MAX = vlw_pkg::SIDE_MAX_DEFAULT,
   localparam int AddrW = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX),
   localparam int DataW = $bits(vlw_pkg::item_type) + AddrW
) (
   input  logic             clock,
   input  logic             reset,
   input  vlw_pkg::cfg_type cfg,
   input  logic             clearing,
   vlw_req_if.sink          req,
   output logic             push_valid,
   input  logic             push_ready,
   output logic [DataW-1:0] push_data
);

   localparam int RelW   = $clog2(SIDE_MAX);
   localparam int SizeW  = $clog2(SIDE_MAX + 1);
   localparam int PlaneW = $clog2(SIDE_MAX * SIDE_MAX);
   localparam int PW     = RelW + SizeW + 1;
   localparam int AW     = PlaneW + SizeW + 1;
   localparam int CW     = vlw_pkg::COORD_W;

   // effective sizes, clamped to the cube side
   logic [SizeW-1:0] sx, sy, sz;
   assign sx = (32'(cfg.size_x) > SIDE_MAX) ? SizeW'(SIDE_MAX) : SizeW'(cfg.size_x);
   assign sy = (32'(cfg.size_y) > SIDE_MAX) ? SizeW'(SIDE_MAX) : SizeW'(cfg.size_y);
   assign sz = (32'(cfg.size_z) > SIDE_MAX) ? SizeW'(SIDE_MAX) : SizeW'(cfg.size_z);

   // stage 1: relative coordinates
   logic                         s1_valid_ff, s1_valid_in;
   logic [1:0]                   s1_op_ff;
   logic [CW-1:0]                s1_rx_ff, s1_ry_ff, s1_rz_ff;
   logic [vlw_pkg::LABEL_W-1:0]  s1_wval_ff;
   logic                         s1_final_ff;

   // stage 2: bounds and plane offset
   logic                         s2_valid_ff, s2_valid_in;
   vlw_pkg::item_type            s2_item_ff, s2_item_in;
   logic [RelW-1:0]              s2_rx_ff;
   logic [PlaneW-1:0]            s2_plane_ff, s2_plane_in;

   // stage 3: linear address
   logic                         s3_valid_ff, s3_valid_in;
   vlw_pkg::item_type            s3_item_ff;
   logic [AddrW-1:0]             s3_addr_ff, s3_addr_in;

   logic rdy1, rdy2, rdy3, take;

   assign rdy3 = !s3_valid_ff || push_ready;
   assign rdy2 = !s2_valid_ff || rdy3;
   assign rdy1 = !s1_valid_ff || rdy2;
   assign req.ready = rdy1 && !clearing;
   assign take = req.valid && req.ready;

   // stage 2 logic
   logic          out_x, out_y, out_z, outside;
   logic [PW-1:0] plane_full;
   always_comb begin
      out_x = s1_rx_ff >= CW'(sx);
      out_y = s1_ry_ff >= CW'(sy);
      out_z = s1_rz_ff >= CW'(sz);
      outside = out_x || out_y || out_z;
      plane_full = PW'(s1_rz_ff[RelW-1:0]) * PW'(sy) + PW'(s1_ry_ff[RelW-1:0]);
      s2_plane_in = plane_full[PlaneW-1:0];
      s2_item_in.op          = s1_op_ff;
      s2_item_in.outside     = outside;
      s2_item_in.rel_x       = outside ? '0 : s1_rx_ff[vlw_pkg::REL_W-1:0];
      s2_item_in.rel_y       = outside ? '0 : s1_ry_ff[vlw_pkg::REL_W-1:0];
      s2_item_in.rel_z       = outside ? '0 : s1_rz_ff[vlw_pkg::REL_W-1:0];
      s2_item_in.write_value = s1_wval_ff;
      s2_item_in.final_req   = s1_final_ff;
   end

   // stage 3 logic
   logic [AW-1:0] addr_full;
   assign addr_full  = AW'(s2_plane_ff) * AW'(sx) + AW'(s2_rx_ff);
   assign s3_addr_in = addr_full[AddrW-1:0];

   // stage valids
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (rdy1) s1_valid_in = take;
      s2_valid_in = s2_valid_ff;
      if (rdy2) s2_valid_in = s1_valid_ff;
      s3_valid_in = s3_valid_ff;
      if (rdy3) s3_valid_in = s2_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff    <= req.op;
         s1_rx_ff    <= req.coord_x - cfg.origin_x;
         s1_ry_ff    <= req.coord_y - cfg.origin_y;
         s1_rz_ff    <= req.coord_z - cfg.origin_z;
         s1_wval_ff  <= req.write_value;
         s1_final_ff <= req.final_req;
      end
      if (rdy2 && s1_valid_ff) begin
         s2_item_ff  <= s2_item_in;
         s2_rx_ff    <= s1_rx_ff[RelW-1:0];
         s2_plane_ff <= s2_plane_in;
      end
      if (rdy3 && s2_valid_ff) begin
         s3_item_ff <= s2_item_ff;
         s3_addr_ff <= s3_addr_in;
      end
   end

   assign push_valid = s3_valid_ff;
   assign push_data  = {s3_item_ff, s3_addr_ff};

endmodule

/* src/vlw_queue.sv */
// Short first-word-fall-through queue between front and back end.
// Depends on vlw_pkg for its default depth.
module vlw_queue #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = vlw_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  logic [DATA_W-1:0] push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output logic [DATA_W-1:0] pop_data
);

   localparam int PtrW = $clog2(DEPTH);
   localparam int CntW = $clog2(DEPTH + 1);

   logic [DATA_W-1:0] entry_ff [DEPTH];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              push, pop;

   assign push_ready = count_ff != CntW'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push = push_valid && push_ready;
   assign pop  = pop_valid && pop_ready;
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

/* src/vlw_back.sv */
// Back end: clears the voxel memory after reset, then reads and resolves one voxel
// per item, writes it when needed and holds the result. Depends on vlw_pkg, vlw_if.
module vlw_back #(
   parameter int SIDE_MAX = vlw_pkg::SIDE_MAX_DEFAULT,
   localparam int AddrW = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX),
   localparam int DataW = $bits(vlw_pkg::item_type) + AddrW
) (
   input  logic                   clock,
   input  logic                   reset,
   input  vlw_pkg::cfg_type       cfg,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  logic [DataW-1:0]       pop_data,
   vlw_rsp_if.source              rsp,
   output vlw_pkg::back_stat_type stat
);

   localparam int Depth = SIDE_MAX * SIDE_MAX * SIDE_MAX;
   localparam int LW    = vlw_pkg::LABEL_W;

   typedef enum logic [1:0] {B_CLEAR, B_IDLE, B_RESOLVE} state_type;

   state_type                   state_ff, state_in;
   logic [AddrW-1:0]            clr_ff, clr_in;
   vlw_pkg::item_type           cur_ff, cur_in;
   logic [AddrW-1:0]            cur_addr_ff, cur_addr_in;
   logic [vlw_pkg::COUNT_W-1:0] count_ff, count_in, count_next;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [2:0]                  rsp_status_ff, rsp_status_in;
   logic [LW-1:0]               rsp_value_ff, rsp_value_in;
   logic [vlw_pkg::REL_W-1:0]   rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in, rsp_z_ff, rsp_z_in;
   logic [vlw_pkg::COUNT_W-1:0] rsp_total_ff, rsp_total_in;

   // voxel memory port signals
   logic [LW-1:0]    voxel_mem [Depth];
   logic [LW-1:0]    rd_data_ff;
   logic             mem_we, mem_re;
   logic [AddrW-1:0] mem_waddr, mem_raddr;
   logic [LW-1:0]    mem_wdata;

   vlw_pkg::item_type pop_item;
   logic [AddrW-1:0]  pop_addr;
   assign pop_item = pop_data[DataW-1:AddrW];
   assign pop_addr = pop_data[AddrW-1:0];

   // resolution of the current item against the old voxel content
   logic          hit_write;
   logic [LW-1:0] new_value;
   logic [2:0]    res_status;
   logic          res_exception;
   always_comb begin
      hit_write     = 1'b0;
      new_value     = cfg.label;
      res_exception = 1'b0;
      res_status    = vlw_pkg::STATUS_ACCESS;
      if (cur_ff.outside) begin
         res_status = vlw_pkg::STATUS_OUTSIDE;
      end else if (cur_ff.op == vlw_pkg::OP_ANNOTATE) begin
         if (rd_data_ff == '0) begin
            hit_write  = 1'b1;
            res_status = vlw_pkg::STATUS_LABELLED;
         end else if (rd_data_ff == cfg.label) begin
            res_status = vlw_pkg::STATUS_SAME;
         end else if (cfg.mode == vlw_pkg::MODE_OVERWRITE) begin
            hit_write  = 1'b1;
            res_status = vlw_pkg::STATUS_OVERWRITTEN;
         end else if (cfg.mode == vlw_pkg::MODE_EXCEPTION) begin
            res_exception = 1'b1;
            res_status    = vlw_pkg::STATUS_EXCEPTION;
         end else begin
            res_status = vlw_pkg::STATUS_PRESERVED;
         end
      end else if (cur_ff.op == vlw_pkg::OP_WRITE) begin
         hit_write = 1'b1;
         new_value = cur_ff.write_value;
      end
      count_next = count_ff;
      if (res_exception && count_ff != vlw_pkg::COUNT_MAX) count_next = count_ff + 1'b1;
   end

   // sequencer: clear sweep, then a read step and a resolve step per item
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cur_in        = cur_ff;
      cur_addr_in   = cur_addr_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_z_in      = rsp_z_ff;
      rsp_total_in  = rsp_total_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_addr_ff;
      mem_wdata     = new_value;
      mem_re        = 1'b0;
      mem_raddr     = pop_addr;
      pop_ready     = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            if (clr_ff == AddrW'(Depth - 1)) state_in = B_IDLE;
            else clr_in = clr_ff + 1'b1;
         end
         B_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               cur_in      = pop_item;
               cur_addr_in = pop_addr;
               mem_re      = 1'b1;
               state_in    = B_RESOLVE;
            end
         end
         B_RESOLVE: begin
            if (!rsp_valid_ff || rsp.ready) begin
               mem_we        = hit_write;
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status;
               rsp_value_in  = cur_ff.outside ? '0 : rd_data_ff;
               rsp_x_in      = cur_ff.rel_x;
               rsp_y_in      = cur_ff.rel_y;
               rsp_z_in      = cur_ff.rel_z;
               rsp_total_in  = count_next;
               count_in      = cur_ff.final_req ? '0 : count_next;
               state_in      = B_IDLE;
            end
         end
         default: state_in = B_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         cur_ff        <= cur_in;
         cur_addr_ff   <= cur_addr_in;
         rsp_status_ff <= rsp_status_in;
         rsp_value_ff  <= rsp_value_in;
         rsp_x_ff      <= rsp_x_in;
         rsp_y_ff      <= rsp_y_in;
         rsp_z_ff      <= rsp_z_in;
         rsp_total_ff  <= rsp_total_in;
      end
   end

   // voxel memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) voxel_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= voxel_mem[mem_raddr];
   end

   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_status_ff;
   assign rsp.read_value      = rsp_value_ff;
   assign rsp.rel_x           = rsp_x_ff;
   assign rsp.rel_y           = rsp_y_ff;
   assign rsp.rel_z           = rsp_z_ff;
   assign rsp.exception_total = rsp_total_ff;

   assign stat.clearing  = state_ff == B_CLEAR;
   assign stat.resolving = state_ff == B_RESOLVE;

endmodule

/* src/voxel_label_writer_core.sv */
// Voxel label writer core. Holds a SIDE_MAX^3 cube of 32-bit labels and runs
// annotate, write and read operations on absolute locations; each request
// transfer gives one response transfer, in order. After reset the voxel memory
// is swept to zero one word a cycle, and no request is taken until the sweep
// ends; register writes are taken throughout. Thereafter the back end takes
// each item through a read state and a resolve-and-write state, with one write
// and one registered read port on the memory, and takes no new item until it
// has resolved the last one. A request reaches the back end through a
// three-stage address pipeline and a four-entry queue.
// Depends on vlw_pkg, vlw_if and all vlw_ modules.
`include "voxel_label_writer_core_macros.svh"

module voxel_label_writer_core #(
   parameter int SIDE_MAX = vlw_pkg::SIDE_MAX_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   vlw_req_if.sink                         req_ch,
   vlw_rsp_if.source                       rsp_ch,
   input  logic                            csr_we,
   input  logic [vlw_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [vlw_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AddrW = $clog2(SIDE_MAX * SIDE_MAX * SIDE_MAX);
   localparam int DataW = $bits(vlw_pkg::item_type) + AddrW;

   vlw_pkg::cfg_type       cfg;
   vlw_pkg::back_stat_type stat;
   logic                   push_valid, push_ready, pop_valid, pop_ready;
   logic [DataW-1:0]       push_data, pop_data;

   vlw_cfg_regs u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   vlw_front #(.SIDE_MAX(SIDE_MAX)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .clearing   (stat.clearing),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   vlw_queue #(.DATA_W(DataW), .DEPTH(vlw_pkg::QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   vlw_back #(.SIDE_MAX(SIDE_MAX)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp       (rsp_ch),
      .stat      (stat)
   );

   // checks
   `VLW_ASSERT_IMPLY(a_no_req_in_clear, clock, reset, stat.clearing, !(req_ch.valid && req_ch.ready))
   `VLW_ASSERT_IMPLY(a_outside_zero, clock, reset, rsp_ch.valid && rsp_ch.status == vlw_pkg::STATUS_OUTSIDE, rsp_ch.read_value == '0 && rsp_ch.rel_x == '0 && rsp_ch.rel_y == '0 && rsp_ch.rel_z == '0)
   `VLW_ASSERT_IMPLY(a_exception_counted, clock, reset, rsp_ch.valid && rsp_ch.status == vlw_pkg::STATUS_EXCEPTION, rsp_ch.exception_total != '0)
   `VLW_ASSERT_NEXT(a_pop_then_resolve, clock, reset, pop_valid && pop_ready, stat.resolving)
   `VLW_ASSERT_NEXT(a_clear_once, clock, reset, !stat.clearing, !stat.clearing)

endmodule

/* tb/voxel_label_writer_core_test.sv */
// Self-checking testbench for voxel_label_writer_core: directed and random label traffic.
// A scoreboard class mirrors the label cube and predicts every response in order.
// Depends on vlw_pkg, vlw_if and the core sources.
module voxel_label_writer_core_test;
   import vlw_pkg::*;

   localparam int          RESET_CYCLES  = 11;
   localparam int          SETTLE_CYCLES = 12;
   localparam int          TAIL_CYCLES   = 24;
   localparam int          HOLD_CYCLES   = 240;
   localparam int          REPORT_LIMIT  = 10;
   localparam int          CUBE_WORDS    = SIDE_MAX_DEFAULT ** 3;
   // sweep of the cube after reset plus the stimulus, several times over
   localparam int          LIMIT_TIME    = 2_000_000;
   localparam logic [1:0]  OP_SPARE      = 2'd3;
   localparam logic [1:0]  MODE_SPARE    = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] z;
      logic [LABEL_W-1:0] wval;
      logic               fin;
   } voxel_req_t;

   typedef struct packed {
      logic [2:0]         status;
      logic [LABEL_W-1:0] prior;
      logic [REL_W-1:0]   rx;
      logic [REL_W-1:0]   ry;
      logic [REL_W-1:0]   rz;
      logic [COUNT_W-1:0] total;
   } voxel_rsp_t;

   // Mirror of the label cube and the queue of responses still owed
   class label_cube_tracker;
      cfg_type            cfg;
      bit [LABEL_W-1:0]   cube_words [0:CUBE_WORDS-1];
      logic [COUNT_W-1:0] exception_count;
      voxel_rsp_t         awaited [$];
      int                 failures;

      function new();
         cfg.label    = 1;
         cfg.mode     = MODE_OVERWRITE;
         cfg.origin_x = '0;
         cfg.origin_y = '0;
         cfg.origin_z = '0;
         cfg.size_x   = SIZE_W'(SIDE_MAX_DEFAULT);
         cfg.size_y   = SIZE_W'(SIDE_MAX_DEFAULT);
         cfg.size_z   = SIZE_W'(SIDE_MAX_DEFAULT);
         exception_count = '0;
         failures = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] value);
         case (index)
            REG_LABEL:    cfg.label    = value;
            REG_MODE:     cfg.mode     = value[1:0];
            REG_ORIGIN_X: cfg.origin_x = value[COORD_W-1:0];
            REG_ORIGIN_Y: cfg.origin_y = value[COORD_W-1:0];
            REG_ORIGIN_Z: cfg.origin_z = value[COORD_W-1:0];
            REG_SIZE_X:   cfg.size_x   = value[SIZE_W-1:0];
            REG_SIZE_Y:   cfg.size_y   = value[SIZE_W-1:0];
            default:      cfg.size_z   = value[SIZE_W-1:0];
         endcase
      endfunction

      // sizes above the cube side are clipped to it
      function int unsigned clip_side(logic [SIZE_W-1:0] s);
         return (int'(s) > SIDE_MAX_DEFAULT) ? SIDE_MAX_DEFAULT : int'(s);
      endfunction

      function void note_request(voxel_req_t r);
         int unsigned        sx, sy, sz, addr;
         logic [COORD_W-1:0] rx, ry, rz;
         logic [LABEL_W-1:0] prior;
         voxel_rsp_t         e;
         sx = clip_side(cfg.size_x);
         sy = clip_side(cfg.size_y);
         sz = clip_side(cfg.size_z);
         rx = r.x - cfg.origin_x;
         ry = r.y - cfg.origin_y;
         rz = r.z - cfg.origin_z;
         e  = '0;
         if (32'(rx) >= sx || 32'(ry) >= sy || 32'(rz) >= sz) begin
            e.status = STATUS_OUTSIDE;
         end else begin
            addr    = (32'(rz) * sy + 32'(ry)) * sx + 32'(rx);
            prior   = cube_words[addr];
            e.prior = prior;
            e.rx    = rx[REL_W-1:0];
            e.ry    = ry[REL_W-1:0];
            e.rz    = rz[REL_W-1:0];
            if (r.op == OP_ANNOTATE) begin
               if (prior == '0) begin
                  cube_words[addr] = cfg.label;
                  e.status = STATUS_LABELLED;
               end else if (prior == cfg.label) begin
                  e.status = STATUS_SAME;
               end else if (cfg.mode == MODE_OVERWRITE) begin
                  cube_words[addr] = cfg.label;
                  e.status = STATUS_OVERWRITTEN;
               end else if (cfg.mode == MODE_EXCEPTION) begin
                  if (exception_count != COUNT_MAX) exception_count = exception_count + 1'b1;
                  e.status = STATUS_EXCEPTION;
               end else begin
                  // preserve, and the spare mode behaves the same
                  e.status = STATUS_PRESERVED;
               end
            end else begin
               // spare op code behaves as a read
               if (r.op == OP_WRITE) cube_words[addr] = r.wval;
               e.status = STATUS_ACCESS;
            end
         end
         e.total = exception_count;
         if (r.fin) exception_count = '0;
         awaited.push_back(e);
      endfunction

      function void check_response(voxel_rsp_t got);
         voxel_rsp_t want;
         if (awaited.size() == 0) begin
            if (failures < REPORT_LIMIT)
               $display("response with nothing pending: status %0d value %h rel %0d/%0d/%0d total %0d",
                        got.status, got.prior, got.rx, got.ry, got.rz, got.total);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.status !== want.status || got.prior !== want.prior || got.rx !== want.rx ||
             got.ry !== want.ry || got.rz !== want.rz || got.total !== want.total) begin
            if (failures < REPORT_LIMIT) begin
               $display("mismatch exp: status %0d value %h rel %0d/%0d/%0d total %0d",
                        want.status, want.prior, want.rx, want.ry, want.rz, want.total);
               $display("         got: status %0d value %h rel %0d/%0d/%0d total %0d",
                        got.status, got.prior, got.rx, got.ry, got.rz, got.total);
            end
            failures++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;
   int                sender_idle_pct;
   int                receiver_stall_pct;
   int                hold_requests;
   label_cube_tracker board;

   vlw_req_if req_bus ();
   vlw_rsp_if rsp_bus ();

   voxel_label_writer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(LIMIT_TIME);
      $display("CHECKS FAILED");
      $finish;
   end

   // Response side: random stalls, plus a long hold-off on request
   initial begin : response_drain
      int   hold_left;
      int   hold_served;
      logic take;
      rsp_bus.ready = 1'b0;
      hold_left   = 0;
      hold_served = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            take = 1'b0;
            hold_left--;
         end else begin
            take = ($urandom_range(99) >= receiver_stall_pct);
         end
         rsp_bus.ready <= take;
      end
   end

   // Check every response transfer against the oldest prediction
   always @(posedge clock) begin : response_monitor
      voxel_rsp_t got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.status = rsp_bus.status;
         got.prior  = rsp_bus.read_value;
         got.rx     = rsp_bus.rel_x;
         got.ry     = rsp_bus.rel_y;
         got.rz     = rsp_bus.rel_z;
         got.total  = rsp_bus.exception_total;
         board.check_response(got);
      end
   end

   // Offer one request from a falling edge; returns at the falling edge after the transfer
   task automatic send_item(input voxel_req_t r);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid   <= 1'b0;
         req_bus.op      <= 2'($urandom);
         req_bus.coord_x <= COORD_W'($urandom);
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.op          <= r.op;
      req_bus.coord_x     <= r.x;
      req_bus.coord_y     <= r.y;
      req_bus.coord_z     <= r.z;
      req_bus.write_value <= r.wval;
      req_bus.final_req   <= r.fin;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(r);
      @(negedge clock);
   endtask

   task automatic send_op(input logic [1:0] op, input logic [COORD_W-1:0] x, y, z,
                          input logic [LABEL_W-1:0] wval, input logic fin);
      voxel_req_t r;
      r.op   = op;
      r.x    = x;
      r.y    = y;
      r.z    = z;
      r.wval = wval;
      r.fin  = fin;
      send_item(r);
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (board.awaited.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Wait for the block to go idle, then write all eight registers back to back
   task automatic program_cube(input logic [LABEL_W-1:0] lbl, input logic [1:0] mode,
                               input logic [COORD_W-1:0] ox, oy, oz,
                               input logic [SIZE_W-1:0] sx, sy, sz);
      logic [CSR_DATA_W-1:0] value [8];
      value[REG_LABEL]    = lbl;
      value[REG_MODE]     = CSR_DATA_W'(mode);
      value[REG_ORIGIN_X] = CSR_DATA_W'(ox);
      value[REG_ORIGIN_Y] = CSR_DATA_W'(oy);
      value[REG_ORIGIN_Z] = CSR_DATA_W'(oz);
      value[REG_SIZE_X]   = CSR_DATA_W'(sx);
      value[REG_SIZE_Y]   = CSR_DATA_W'(sy);
      value[REG_SIZE_Z]   = CSR_DATA_W'(sz);
      drain_responses();
      for (int i = 0; i < 8; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= value[i];
         board.set_register(CSR_INDEX_W'(i), value[i]);
         @(negedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [LABEL_W-1:0] pick_label();
      logic [LABEL_W-1:0] v;
      v = ($urandom_range(1) == 0) ? LABEL_W'($urandom_range(1, 4)) : LABEL_W'($urandom);
      if (v == '0) v = 1;
      return v;
   endfunction

   // Mostly in-cube locations, some just past an edge, a few anywhere
   function automatic voxel_req_t make_request();
      voxel_req_t         r;
      int unsigned        side [3];
      logic [COORD_W-1:0] base [3];
      logic [COORD_W-1:0] pos [3];
      int unsigned        roll;
      int unsigned        pick;
      int                 axis;
      side[0] = board.clip_side(board.cfg.size_x);
      side[1] = board.clip_side(board.cfg.size_y);
      side[2] = board.clip_side(board.cfg.size_z);
      base[0] = board.cfg.origin_x;
      base[1] = board.cfg.origin_y;
      base[2] = board.cfg.origin_z;
      for (int i = 0; i < 3; i++)
         pos[i] = base[i] + COORD_W'((side[i] == 0) ? $urandom_range(63)
                                                      : $urandom_range(side[i] - 1));
      roll = $urandom_range(99);
      if (roll >= 94) begin
         for (int i = 0; i < 3; i++) pos[i] = COORD_W'($urandom);
      end else if (roll >= 84) begin
         axis = $urandom_range(2);
         pos[axis] = base[axis] + COORD_W'(side[axis] + $urandom_range(3));
      end
      pick = $urandom_range(99);
      r.op = (pick < 55) ? OP_ANNOTATE : (pick < 75) ? OP_WRITE : (pick < 93) ? OP_READ : OP_SPARE;
      r.x  = pos[0];
      r.y  = pos[1];
      r.z  = pos[2];
      case ($urandom_range(3))
         0:       r.wval = '0;
         1:       r.wval = board.cfg.label;
         2:       r.wval = LABEL_W'($urandom_range(1, 4));
         default: r.wval = LABEL_W'($urandom);
      endcase
      r.fin = ($urandom_range(99) < 8);
      return r;
   endfunction

   task automatic run_phase(input logic [LABEL_W-1:0] lbl, input logic [1:0] mode,
                            input logic [COORD_W-1:0] ox, oy, oz,
                            input logic [SIZE_W-1:0] sx, sy, sz,
                            input int idle_pct, input int stall_pct, input int count,
                            input bit squeeze);
      program_cube(lbl, mode, ox, oy, oz, sx, sy, sz);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      if (squeeze) hold_requests++;
      repeat (count) send_item(make_request());
   endtask

   initial begin : stimulus
      board = new();
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = '0;
      csr_data            = '0;
      req_bus.valid       = 1'b0;
      req_bus.op          = OP_READ;
      req_bus.coord_x     = '0;
      req_bus.coord_y     = '0;
      req_bus.coord_z     = '0;
      req_bus.write_value = '0;
      req_bus.final_req   = 1'b0;
      sender_idle_pct     = 0;
      receiver_stall_pct  = 0;
      hold_requests       = 0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed: every status, both ends of the cube, the spare codes
      program_cube(32'd5, MODE_OVERWRITE, 0, 0, 0, 64, 64, 64);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_WRITE, 0, 0, 0, 32'd9, 1'b0);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_READ, 63, 63, 63, $urandom, 1'b0);
      send_op(OP_WRITE, 63, 63, 63, 32'hFFFF_FFFF, 1'b0);
      send_op(OP_SPARE, 63, 63, 63, 32'd0, 1'b0);
      send_op(OP_ANNOTATE, 64, 0, 0, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, $urandom, 1'b0);
      send_op(OP_WRITE, 1, 0, 0, 32'd7, 1'b0);
      program_cube(32'd5, MODE_PRESERVE, 0, 0, 0, 64, 64, 64);
      send_op(OP_ANNOTATE, 1, 0, 0, $urandom, 1'b0);
      program_cube(32'd5, MODE_SPARE, 0, 0, 0, 64, 64, 64);
      send_op(OP_ANNOTATE, 1, 0, 0, $urandom, 1'b0);
      // exceptions count up and clear after the last of a batch
      program_cube(32'hFFFF_FFFF, MODE_EXCEPTION, 0, 0, 0, 64, 64, 64);
      send_op(OP_ANNOTATE, 1, 0, 0, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b1);
      send_op(OP_READ, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_WRITE, 2, 0, 0, 32'hFFFF_FFFF, 1'b0);
      send_op(OP_ANNOTATE, 2, 0, 0, $urandom, 1'b0);
      // origin at the top of the range, coordinates wrap through zero; oversize sides
      program_cube(32'd1, MODE_OVERWRITE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 127, 127, 127);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 62, 62, 62, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 63, 0, 0, $urandom, 1'b0);
      send_op(OP_READ, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, $urandom, 1'b0);
      // zero size: nothing is inside
      program_cube(32'd1, MODE_OVERWRITE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0, 0);
      send_op(OP_ANNOTATE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, $urandom, 1'b0);
      send_op(OP_WRITE, 0, 0, 0, $urandom, 1'b1);
      program_cube(32'd3, MODE_EXCEPTION, 0, 0, 0, 1, 1, 1);
      send_op(OP_ANNOTATE, 0, 0, 0, $urandom, 1'b0);
      send_op(OP_ANNOTATE, 1, 0, 0, $urandom, 1'b0);

      // Random phases across modes, cube shapes and idling patterns
      run_phase(pick_label(), MODE_OVERWRITE, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), 4, 4, 4, 0, 0, 90, 1'b0);
      run_phase(pick_label(), MODE_PRESERVE, 20'hFFFFC, 20'hFFFFE, 20'hFFFFF,
                8, 3, 5, 73, 0, 90, 1'b0);
      run_phase(pick_label(), MODE_EXCEPTION, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), 2, 2, 2, 0, 73, 90, 1'b0);
      run_phase(pick_label(), MODE_SPARE, 0, 0, 0, 64, 64, 64, 7, 7, 80, 1'b0);
      // long receiver hold-off while requests keep coming
      run_phase(32'hFFFF_FFFF, MODE_EXCEPTION, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), 1, 1, 1, 0, 0, 90, 1'b1);
      run_phase(pick_label(), MODE_OVERWRITE, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                127, 1, 100, 73, 0, 90, 1'b0);
      run_phase(pick_label(), MODE_EXCEPTION, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), 0, 5, 5, 0, 73, 40, 1'b0);
      run_phase(pick_label(), MODE_EXCEPTION, COORD_W'($urandom), COORD_W'($urandom),
                COORD_W'($urandom), 3, 7, 2, 7, 7, 90, 1'b0);

      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (board.failures == 0 && board.awaited.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
